>>> rtl/nps_pkg.sv
// Shared constants, codes and controller/datapath types for the priority scheduler.
`default_nettype none

package nps_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int PRIO_W    = 4;
  localparam int TIME_W    = 16;
  localparam int CLK_W     = 17;
  localparam int ACT_W     = 5;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AGING_ON     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGING_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 2'd3;

  localparam logic [TIME_W-1:0] AGING_THRESH_RST = 16'd5;
  localparam logic [TIME_W-1:0] TIME_LIMIT_RST   = 16'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_we;
    logic restart;
    logic scan_start;
    logic scan_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic no_slots;
    logic scan_last;
    logic out_busy;
  } ctl_status_t;

endpackage

`default_nettype wire

>>> rtl/nps_channels.sv
// Valid/ready channel interfaces: request items, result items and register writes.
`default_nettype none

interface nps_in_if;
  logic                         valid;
  logic                         ready;
  logic [nps_pkg::CMD_W-1:0]    cmd;
  logic [nps_pkg::IDX_W-1:0]    slot;
  logic [nps_pkg::PRIO_W-1:0]   base_priority;
  logic [nps_pkg::TIME_W-1:0]   arrival;
  logic [nps_pkg::TIME_W-1:0]   burst;
  modport source (output valid, cmd, slot, base_priority, arrival, burst, input ready);
  modport sink   (input valid, cmd, slot, base_priority, arrival, burst, output ready);
endinterface

interface nps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ran;
  logic [nps_pkg::IDX_W-1:0]    slot_run;
  logic                         began;
  logic                         completed;
  logic [nps_pkg::CLK_W-1:0]    fin_time;
  logic [nps_pkg::CLK_W-1:0]    time_now;
  logic                         all_done;
  modport source (output valid, ran, slot_run, began, completed, fin_time, time_now,
                  all_done, input ready);
  modport sink   (input valid, ran, slot_run, began, completed, fin_time, time_now,
                  all_done, output ready);
endinterface

interface nps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nps_pkg::CFG_IDX_W-1:0]  index;
  logic [nps_pkg::CFG_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/nps_ctrl.sv
// Sequencing state machine: accept, slot scan, finish and result hand-off.
`default_nettype none

module nps_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [nps_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_ready,
  input  nps_pkg::ctl_status_t      sts,
  output nps_pkg::ctl_cmd_t         ctl
);
  import nps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (in_cmd == CMD_TICK)) begin
          // a finished run or an empty table skips straight to the quantum update
          state_next = (sts.done || sts.no_slots) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        ctl.load_we    = in_valid && (in_cmd == CMD_LOAD);
        ctl.restart    = in_valid && (in_cmd == CMD_RESTART);
        ctl.scan_start = in_valid && (in_cmd == CMD_TICK);
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
      end
      ST_FINISH: begin
        ctl.finish = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/nps_datapath.sv
// Slot table, configuration registers, aging/selection scan and result register.
`default_nettype none

module nps_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  nps_pkg::ctl_cmd_t             ctl,
  output nps_pkg::ctl_status_t          sts,
  input  logic                          cfg_we,
  input  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nps_pkg::CFG_W-1:0]     cfg_data,
  input  logic [nps_pkg::IDX_W-1:0]     in_slot,
  input  logic [nps_pkg::PRIO_W-1:0]    in_base_priority,
  input  logic [nps_pkg::TIME_W-1:0]    in_arrival,
  input  logic [nps_pkg::TIME_W-1:0]    in_burst,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ran,
  output logic [nps_pkg::IDX_W-1:0]     out_slot_run,
  output logic                          out_began,
  output logic                          out_completed,
  output logic [nps_pkg::CLK_W-1:0]     out_fin_time,
  output logic [nps_pkg::CLK_W-1:0]     out_time_now,
  output logic                          out_all_done
);
  import nps_pkg::*;

  // configuration
  logic              aging_on;
  logic [TIME_W-1:0] age_thresh;
  logic [TIME_W-1:0] time_limit;
  logic [ACT_W-1:0]  active_count;

  // slot table
  logic [PRIO_W-1:0] prio_base      [NUM_SLOTS];
  logic [PRIO_W-1:0] prio_effective [NUM_SLOTS];
  logic [TIME_W-1:0] arrive_at      [NUM_SLOTS];
  logic [TIME_W-1:0] left_quanta    [NUM_SLOTS];
  logic [TIME_W-1:0] wait_count     [NUM_SLOTS];
  logic [TIME_W-1:0] burst_total    [NUM_SLOTS];
  logic              started_flag   [NUM_SLOTS];
  logic              finished_flag  [NUM_SLOTS];

  logic [CLK_W-1:0]  clock_time;
  logic              running_valid;
  logic [IDX_W-1:0]  running_slot;
  logic              done_flag;

  // scan state
  logic [IDX_W-1:0]  scan_idx;
  logic              best_found;
  logic [PRIO_W-1:0] lead_prio;
  logic [TIME_W-1:0] best_arr;
  logic [IDX_W-1:0]  best_slot;

  logic [ACT_W-1:0]  n_active;
  logic [TIME_W-1:0] load_burst;

  // scan step signals
  logic              cur_waiting;
  logic [TIME_W:0]   wait_inc;
  logic [PRIO_W-1:0] aged_prio;
  logic [TIME_W-1:0] aged_wait;
  logic [PRIO_W-1:0] cand_prio;
  logic              sel_en;
  logic              cand_better;
  logic              take;

  // finish signals
  logic              run_v;
  logic [IDX_W-1:0]  run_s;
  logic              stop_now;
  logic              last_quantum;
  logic [CLK_W-1:0]  clock_inc;

  assign n_active   = (active_count > ACT_W'(NUM_SLOTS)) ? ACT_W'(NUM_SLOTS) : active_count;
  assign load_burst = (in_burst == '0) ? TIME_W'(1) : in_burst;

  assign sts.done      = done_flag;
  assign sts.no_slots  = (n_active == '0);
  assign sts.scan_last = (ACT_W'(scan_idx) == ACT_W'(n_active - ACT_W'(1)));
  assign sts.out_busy  = out_valid && !out_ready;

  always_comb begin
    cur_waiting = !finished_flag[scan_idx] && !started_flag[scan_idx] &&
                  (CLK_W'(arrive_at[scan_idx]) <= clock_time);
    wait_inc  = {1'b0, wait_count[scan_idx]} + (TIME_W+1)'(1);
    aged_prio = prio_effective[scan_idx];
    aged_wait = wait_inc[TIME_W-1:0];
    if (wait_inc >= {1'b0, age_thresh}) begin
      if (prio_effective[scan_idx] > PRIO_W'(1)) begin
        aged_prio = prio_effective[scan_idx] - PRIO_W'(1);
        aged_wait = '0;
      end else begin
        // already at the floor: counter parks at the threshold
        aged_wait = age_thresh;
      end
    end
    cand_prio   = aging_on ? aged_prio : prio_base[scan_idx];
    sel_en      = !running_valid && (clock_time < CLK_W'(time_limit));
    cand_better = !best_found || (cand_prio < lead_prio) ||
                  ((cand_prio == lead_prio) && (arrive_at[scan_idx] < best_arr));
    take        = sel_en && cur_waiting && cand_better;
  end

  always_comb begin
    run_v        = best_found || running_valid;
    run_s        = best_found ? best_slot : running_slot;
    stop_now     = (clock_time >= CLK_W'(time_limit)) && !run_v;
    last_quantum = (left_quanta[run_s] <= TIME_W'(1));
    clock_inc    = clock_time + CLK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aging_on     <= 1'b0;
      age_thresh   <= AGING_THRESH_RST;
      time_limit   <= TIME_LIMIT_RST;
      active_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AGING_ON:     aging_on     <= cfg_data[0];
        REG_AGING_THRESH: age_thresh   <= cfg_data;
        REG_TIME_LIMIT:   time_limit   <= cfg_data;
        REG_ACTIVE_COUNT: active_count <= cfg_data[ACT_W-1:0];
        default:          aging_on     <= aging_on;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
      lead_prio  <= '0;
      best_arr   <= '0;
      best_slot  <= '0;
    end else if (ctl.scan_start) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
    end else if (ctl.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (take) begin
        best_found <= 1'b1;
        lead_prio  <= cand_prio;
        best_arr   <= arrive_at[scan_idx];
        best_slot  <= scan_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        prio_base[i]      <= '0;
        prio_effective[i] <= '0;
        arrive_at[i]      <= '0;
        left_quanta[i]    <= '0;
        wait_count[i]     <= '0;
        burst_total[i]    <= '0;
        started_flag[i]   <= 1'b0;
        finished_flag[i]  <= 1'b0;
      end
      clock_time    <= '0;
      running_valid <= 1'b0;
      running_slot  <= '0;
      done_flag     <= 1'b0;
    end else if (ctl.restart) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        prio_effective[i] <= prio_base[i];
        wait_count[i]     <= '0;
        left_quanta[i]    <= burst_total[i];
        started_flag[i]   <= 1'b0;
        finished_flag[i]  <= 1'b0;
      end
      clock_time    <= '0;
      running_valid <= 1'b0;
      running_slot  <= '0;
      done_flag     <= 1'b0;
    end else if (ctl.load_we) begin
      prio_base[in_slot]      <= in_base_priority;
      prio_effective[in_slot] <= in_base_priority;
      arrive_at[in_slot]      <= in_arrival;
      burst_total[in_slot]    <= load_burst;
      left_quanta[in_slot]    <= load_burst;
      wait_count[in_slot]     <= '0;
      started_flag[in_slot]   <= 1'b0;
      finished_flag[in_slot]  <= 1'b0;
      // reloading the running slot cancels that task
      if (running_valid && (running_slot == in_slot)) begin
        running_valid <= 1'b0;
      end
    end else if (ctl.scan_step) begin
      if (aging_on && cur_waiting) begin
        prio_effective[scan_idx] <= aged_prio;
        wait_count[scan_idx]     <= aged_wait;
      end
    end else if (ctl.finish && !done_flag) begin
      if (best_found) begin
        started_flag[best_slot] <= 1'b1;
        running_slot            <= best_slot;
        running_valid           <= 1'b1;
      end
      if (stop_now) begin
        done_flag <= 1'b1;
      end else begin
        if (run_v) begin
          if (last_quantum) begin
            left_quanta[run_s]   <= '0;
            finished_flag[run_s] <= 1'b1;
            running_valid        <= 1'b0;
          end else begin
            left_quanta[run_s] <= left_quanta[run_s] - TIME_W'(1);
          end
        end
        clock_time <= clock_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_time_now  <= clock_time;
      out_ran       <= 1'b0;
      out_slot_run  <= '0;
      out_began     <= 1'b0;
      out_completed <= 1'b0;
      out_fin_time  <= '0;
      out_all_done  <= done_flag;
      if (!done_flag) begin
        out_began    <= best_found;
        out_all_done <= stop_now;
        if (!stop_now && run_v) begin
          out_ran      <= 1'b1;
          out_slot_run <= run_s;
          if (last_quantum) begin
            out_completed <= 1'b1;
            out_fin_time  <= clock_inc;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/nonpreemptive_priority_scheduler_unit.sv
// Top level of the non-preemptive priority scheduler with aging.
// Channels: req (sink) takes items with cmd = load, tick or restart; rsp
// (source) returns one result per tick; cfg (sink, always ready) writes the
// aging enable, aging threshold, time limit and active count by index 0..3.
// Load and restart give no result. A tick runs the accepting cycle, an
// aging/selection scan step for each of the n = min(active_count, 16)
// participating slots, then a finish step that updates the running task and
// the clock and loads the result register, which raises rsp.valid. With no
// participating slots, or once the run is over, the scan is skipped and the
// tick goes from the accepting cycle straight to the finish step. req.ready
// is high only while no tick is in progress, so a new item is not accepted
// until the last tick has finished. A result waiting in the output register
// does not block acceptance; if rsp stalls, the next tick holds in its final
// cycle until the register frees. Reset clears the slot table, the clock and
// the run state, and loads the register reset values (threshold 5, time
// limit 100).
`default_nettype none

module nonpreemptive_priority_scheduler_unit (
  input  logic      clk,
  input  logic      rst,
  nps_in_if.sink    req,
  nps_out_if.source rsp,
  nps_cfg_if.sink   cfg
);
  import nps_pkg::*;

  ctl_cmd_t    ctl;
  ctl_status_t sts;

  assign cfg.ready = 1'b1;

  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  nps_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .in_slot          (req.slot),
    .in_base_priority (req.base_priority),
    .in_arrival       (req.arrival),
    .in_burst         (req.burst),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_ran          (rsp.ran),
    .out_slot_run     (rsp.slot_run),
    .out_began        (rsp.began),
    .out_completed    (rsp.completed),
    .out_fin_time     (rsp.fin_time),
    .out_time_now     (rsp.time_now),
    .out_all_done     (rsp.all_done)
  );

endmodule

`default_nettype wire

>>> rtl/nps_checker.sv
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none

module nps_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [nps_pkg::CMD_W-1:0]   req_cmd,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_ran,
  input logic [nps_pkg::IDX_W-1:0]   rsp_slot_run,
  input logic                        rsp_began,
  input logic                        rsp_completed,
  input logic [nps_pkg::CLK_W-1:0]   rsp_fin_time,
  input logic [nps_pkg::CLK_W-1:0]   rsp_time_now,
  input logic                        rsp_all_done
);
  import nps_pkg::*;

  // a stalled item stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_run) && $stable(rsp_time_now))
    else $error("rsp item changed while stalled");

  // a tick occupies the block for at least the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_cmd == CMD_TICK) |=> !req_ready)
    else $error("req ready straight after a tick");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_all_done |-> !rsp_ran && !rsp_began && !rsp_completed)
    else $error("activity reported after run over");

  a_fin_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_completed |->
      rsp_ran && (rsp_fin_time == CLK_W'(rsp_time_now + CLK_W'(1))))
    else $error("completion without run or wrong completion time");

  a_began_ran: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_began |-> rsp_ran)
    else $error("start reported without a quantum run");

endmodule

bind nonpreemptive_priority_scheduler_unit nps_checker u_nps_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_cmd       (req.cmd),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_ran       (rsp.ran),
  .rsp_slot_run  (rsp.slot_run),
  .rsp_began     (rsp.began),
  .rsp_completed (rsp.completed),
  .rsp_fin_time  (rsp.fin_time),
  .rsp_time_now  (rsp.time_now),
  .rsp_all_done  (rsp.all_done)
);

`default_nettype wire
